>>> rtl/core/ppte_pkg.sv
package ppte_pkg;

  localparam logic [1:0] STATUS_MEASURED = 2'd0;
  localparam logic [1:0] STATUS_FIRST    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

  localparam logic       CMD_REQUEST = 1'b0;

  localparam logic [1:0] RD_PREV = 2'd0;
  localparam logic [1:0] RD_CUR  = 2'd1;
  localparam logic [1:0] RD_LAST = 2'd2;

  localparam logic [1:0] DIV_TPUT = 2'd1;
  localparam logic [1:0] DIV_INV  = 2'd2;
  localparam logic [1:0] DIV_MEAN = 2'd3;

  localparam logic [6:0] STEPS_TPUT = 7'd35;
  localparam logic [6:0] STEPS_INV  = 7'd56;
  localparam logic [6:0] STEPS_MEAN = 7'd64;

  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [15:0] MIN_RATIO = 16'd80;
  localparam logic [7:0]  SAMPLE_COUNT_RESET = 8'd4;

  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_slot;
    logic [1:0] rd_sel;
    logic       cap_prev;
    logic       cap_last;
    logic       cap_cur;
    logic       new_entry;
    logic       req_done;
    logic       set_unknown;
    logic       set_rtt;
    logic       first_data;
    logic       gap_calc;
    logic       cap_tput;
    logic       acc_update;
    logic       mul;
    logic       cap_mean;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_data;
    logic found;
    logic prev_found;
    logic last_data_set;
    logic tput_valid;
    logic sample_done;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/ppte_div.sv
module ppte_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  input  logic [6:0]  steps,
  output logic        done,
  output logic [63:0] quotient
);

  logic [6:0]  cnt;
  logic [63:0] dsh;
  logic [47:0] den;
  logic [47:0] remainder;
  logic [48:0] trial;
  logic [48:0] diff;
  logic        ge;

  assign trial = {remainder, dsh[63]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= steps;
      end else if (cnt != 7'd0) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsh       <= dividend << (7'd64 - steps);
      den       <= divisor;
      remainder <= '0;
      quotient  <= '0;
    end else if (cnt != 7'd0) begin
      dsh       <= {dsh[62:0], 1'b0};
      remainder <= ge ? diff[47:0] : trial[47:0];
      quotient  <= {quotient[62:0], ge};
    end
  end

endmodule

>>> rtl/core/ppte_datapath.sv
module ppte_datapath #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ppte_pkg::dp_cmd_t  cmd,
  output ppte_pkg::dp_sts_t  sts,
  input  logic [111:0]       s_tdata,
  input  logic [1:0]         s_tuser,
  input  logic [7:0]         sample_count,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [103:0]       m_tdata,
  output logic [3:0]         m_tuser
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);

  logic        in_cmd;
  logic [15:0] in_seg;
  logic [23:0] in_chunk;
  logic [47:0] in_t;
  logic [15:0] in_size;
  logic [7:0]  in_hops;
  logic        in_first;

  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] prev_slot;
  logic [SLOT_W-1:0] rd_addr;

  logic [39:0] tag_mem [WINDOW_DEPTH];
  logic [47:0] rft_mem [WINDOW_DEPTH];
  logic [47:0] dft_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] present;
  logic [39:0] tag_q;
  logic [47:0] rft_q;
  logic [47:0] dft_q;

  logic        p_found;
  logic        p_same;
  logic [47:0] p_rft;
  logic [47:0] p_dft;
  logic        c_found;
  logic [47:0] c_rft;

  logic              last_request_set;
  logic              last_data_set;
  logic [SLOT_W-1:0] last_data_slot;

  logic        g_neg;
  logic        g_valid;
  logic [47:0] g_mag;
  logic [22:0] g_gap;

  logic [7:0]  samples;
  logic [47:0] inv_sum;
  logic [27:0] mean_num;

  logic [1:0]  res_status;
  logic [31:0] res_rtt;
  logic [7:0]  res_hops;
  logic [31:0] res_tput;
  logic        res_tv;
  logic [31:0] res_st;
  logic        res_sv;

  logic [63:0] div_dividend;
  logic [47:0] div_divisor;
  logic [6:0]  div_steps;
  logic        div_done;
  logic [63:0] div_q;

  logic        first_overall;
  logic        dft_we;
  logic [47:0] dft_wdata;
  logic [47:0] dftp;
  logic [48:0] gap;
  logic [48:0] rtt_first;
  logic [48:0] gap_abs;
  logic [48:0] rtt_diff;
  logic [48:0] sum;
  logic [7:0]  need;
  logic [7:0]  samples_inc;
  logic [23:0] size80;

  ppte_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    unique case (cmd.div_sel)
      ppte_pkg::DIV_TPUT: begin
        div_dividend = {29'd0, in_size, 19'd0};
        div_divisor  = g_mag;
        div_steps    = ppte_pkg::STEPS_TPUT;
      end
      ppte_pkg::DIV_INV: begin
        div_dividend = {8'd0, g_gap, 33'd0};
        div_divisor  = {32'd0, in_size};
        div_steps    = ppte_pkg::STEPS_INV;
      end
      default: begin
        div_dividend = {mean_num, 36'd0};
        div_divisor  = inv_sum;
        div_steps    = ppte_pkg::STEPS_MEAN;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.rd_sel)
      ppte_pkg::RD_CUR:  rd_addr = cur_slot;
      ppte_pkg::RD_LAST: rd_addr = last_data_slot;
      default:           rd_addr = prev_slot;
    endcase
  end

  assign first_overall = !p_found && !last_request_set;
  assign dft_we        = cmd.new_entry || cmd.first_data || cmd.gap_calc;
  assign dft_wdata     = (cmd.new_entry && !first_overall) ? 48'd0 : in_t;

  // window memories
  always_ff @(posedge clk) begin
    tag_q <= tag_mem[rd_addr];
    rft_q <= rft_mem[rd_addr];
    dft_q <= dft_mem[rd_addr];
    if (cmd.new_entry) begin
      tag_mem[cur_slot] <= {in_seg, in_chunk};
      rft_mem[cur_slot] <= in_t;
    end
    if (dft_we) begin
      dft_mem[cur_slot] <= dft_wdata;
    end
  end

  // gap and rtt of the preceding chunk
  assign dftp      = p_same ? in_t : p_dft;
  assign gap       = {1'b0, in_t} - {1'b0, dftp};
  assign rtt_first = {1'b0, dftp} - {1'b0, p_rft};
  assign gap_abs   = gap[48] ? (49'd0 - gap) : gap;
  assign size80    = {8'd0, in_size} * {8'd0, ppte_pkg::MIN_RATIO};
  assign rtt_diff  = {1'b0, in_t} - {1'b0, c_rft};

  assign sum         = {1'b0, inv_sum} + {1'b0, div_q[47:0]};
  assign need        = (sample_count == 8'd0) ? 8'd1 : sample_count;
  assign samples_inc = samples + 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_seg     <= s_tdata[15:0];
      in_chunk   <= s_tdata[39:16];
      in_t       <= s_tdata[87:40];
      in_size    <= s_tdata[103:88];
      in_hops    <= s_tdata[111:104];
      in_cmd     <= s_tuser[0];
      in_first   <= s_tuser[1];
      res_status <= ppte_pkg::STATUS_MEASURED;
      res_rtt    <= '0;
      res_hops   <= '0;
      res_tput   <= '0;
      res_tv     <= 1'b0;
      res_st     <= '0;
      res_sv     <= 1'b0;
    end
    if (cmd.cap_slot) begin
      cur_slot  <= in_chunk[SLOT_W-1:0];
      prev_slot <= in_chunk[SLOT_W-1:0] - SLOT_W'(1);
    end
    if (cmd.cap_prev) begin
      p_found <= (in_chunk != 24'd0) && present[prev_slot] &&
                 (tag_q == {in_seg, in_chunk - 24'd1});
      p_same  <= 1'b0;
      p_rft   <= rft_q;
      p_dft   <= dft_q;
    end
    if (cmd.cap_last) begin
      p_same <= (last_data_slot == cur_slot);
      p_rft  <= rft_q;
      p_dft  <= dft_q;
    end
    if (cmd.cap_cur) begin
      c_found <= present[cur_slot] && (tag_q == {in_seg, in_chunk});
      c_rft   <= rft_q;
    end
    if (cmd.set_unknown) begin
      res_status <= ppte_pkg::STATUS_UNKNOWN;
    end
    if (cmd.set_rtt) begin
      res_hops <= in_hops;
      if (rtt_diff[48]) begin
        res_rtt <= '0;
      end else if (rtt_diff[47:32] != 16'd0) begin
        res_rtt <= '1;
      end else begin
        res_rtt <= rtt_diff[31:0];
      end
    end
    if (cmd.first_data) begin
      res_status <= ppte_pkg::STATUS_FIRST;
    end
    if (cmd.gap_calc) begin
      g_neg   <= gap[48];
      g_mag   <= (gap_abs == 49'd0) ? 48'd1 : gap_abs[47:0];
      g_gap   <= gap[22:0];
      g_valid <= !gap[48] && (gap != 49'd0) && !rtt_first[48] && (rtt_first != 49'd0) &&
                 ({25'd0, size80} > gap) && !in_first;
    end
    if (cmd.cap_tput) begin
      res_tv <= g_valid;
      if (g_neg) begin
        res_tput <= (div_q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
      end else begin
        res_tput <= (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
      end
    end
    if (cmd.mul) begin
      mean_num <= {20'd0, samples} * {8'd0, ppte_pkg::US_PER_S};
    end
    if (cmd.cap_mean) begin
      res_sv <= 1'b1;
      res_st <= (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present          <= '0;
      last_request_set <= 1'b0;
      last_data_set    <= 1'b0;
      last_data_slot   <= '0;
      samples          <= '0;
      inv_sum          <= '0;
    end else begin
      if (cmd.new_entry) begin
        present[cur_slot] <= 1'b1;
      end
      if (cmd.req_done) begin
        last_request_set <= 1'b1;
      end
      if (cmd.first_data || cmd.gap_calc) begin
        last_data_slot <= cur_slot;
        last_data_set  <= 1'b1;
      end
      if (cmd.acc_update) begin
        samples <= samples_inc;
        inv_sum <= sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
      end
      if (cmd.cap_mean) begin
        samples <= '0;
        inv_sum <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {res_st, res_tput, res_hops, res_rtt};
      m_tuser <= {res_sv, res_tv, res_status};
    end
  end

  assign sts.is_data       = (in_cmd != ppte_pkg::CMD_REQUEST);
  assign sts.found         = c_found;
  assign sts.prev_found    = p_found;
  assign sts.last_data_set = last_data_set;
  assign sts.tput_valid    = g_valid;
  assign sts.sample_done   = samples_inc >= need;
  assign sts.div_done      = div_done;
  assign sts.out_free      = !m_tvalid || m_tready;

endmodule

>>> rtl/core/ppte_ctrl.sv
module ppte_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ppte_pkg::dp_sts_t  sts,
  output ppte_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SLOT   = 4'd1;
  localparam logic [3:0] S_MEAN   = 4'd2;
  localparam logic [3:0] S_RDP    = 4'd3;
  localparam logic [3:0] S_RDC    = 4'd4;
  localparam logic [3:0] S_CAPC   = 4'd5;
  localparam logic [3:0] S_EVAL   = 4'd6;
  localparam logic [3:0] S_RDL    = 4'd7;
  localparam logic [3:0] S_GAP    = 4'd8;
  localparam logic [3:0] S_TPUT   = 4'd9;
  localparam logic [3:0] S_TPUTW  = 4'd10;
  localparam logic [3:0] S_INV    = 4'd11;
  localparam logic [3:0] S_INVW   = 4'd12;
  localparam logic [3:0] S_MUL    = 4'd13;
  localparam logic [3:0] S_MEANW  = 4'd14;
  localparam logic [3:0] S_PUT    = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = ppte_pkg::RD_PREV;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd.cap_slot = 1'b1;
        state_next   = S_RDP;
      end
      S_RDP: begin
        state_next = S_RDC;
      end
      S_RDC: begin
        cmd.cap_prev = 1'b1;
        cmd.rd_sel   = ppte_pkg::RD_CUR;
        state_next   = S_CAPC;
      end
      S_CAPC: begin
        cmd.cap_cur = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.is_data) begin
          cmd.new_entry = !sts.found;
          cmd.req_done  = 1'b1;
          state_next    = S_IDLE;
        end else if (!sts.found) begin
          cmd.set_unknown = 1'b1;
          state_next      = S_PUT;
        end else begin
          cmd.set_rtt = 1'b1;
          if (!sts.prev_found && !sts.last_data_set) begin
            cmd.first_data = 1'b1;
            state_next     = S_PUT;
          end else if (!sts.prev_found) begin
            cmd.rd_sel = ppte_pkg::RD_LAST;
            state_next = S_RDL;
          end else begin
            state_next = S_GAP;
          end
        end
      end
      S_RDL: begin
        cmd.cap_last = 1'b1;
        state_next   = S_GAP;
      end
      S_GAP: begin
        cmd.gap_calc = 1'b1;
        state_next   = S_TPUT;
      end
      S_TPUT: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ppte_pkg::DIV_TPUT;
        state_next    = S_TPUTW;
      end
      S_TPUTW: begin
        if (sts.div_done) begin
          cmd.cap_tput = 1'b1;
          state_next   = sts.tput_valid ? S_INV : S_PUT;
        end
      end
      S_INV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ppte_pkg::DIV_INV;
        state_next    = S_INVW;
      end
      S_INVW: begin
        if (sts.div_done) begin
          cmd.acc_update = 1'b1;
          state_next     = sts.sample_done ? S_MUL : S_PUT;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_MEAN;
      end
      S_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ppte_pkg::DIV_MEAN;
        state_next    = S_MEANW;
      end
      S_MEANW: begin
        if (sts.div_done) begin
          cmd.cap_mean = 1'b1;
          state_next   = S_PUT;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/packet_pair_throughput_estimator.sv
// packet_pair_throughput_estimator
// s channel: one beat per event, request sent (tuser cmd 0) or data received (cmd 1).
// a request beat gives no result; every data beat gives exactly one m beat with
// status, rtt, hop count, packet-pair throughput and, when a mean completes, the
// harmonic mean throughput in bit/s.
// events are handled one at a time by a controller over a shared radix-2 divider;
// a request reads the previous and the current window slot, from the chunk number;
// an unknown chunk or first data gives its result after those reads; other data
// runs the throughput division (35 divider steps), first reading the last data
// slot when the previous chunk is not found; a valid sample adds the inverse
// division (56 steps), and one that completes a mean the mean division (64 steps).
// the m side has its own output register: the next event is taken while a result
// waits, and only the hand-off of the following result waits on m_tready.
// sample_count is written over the apb port at any address with paddr[2] low (0 to 3), reset value 4.
// rst clears the window valid bits, the history flags and the running mean;
// the window memories need no clearing, so the block is ready right after reset.
module packet_pair_throughput_estimator #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // segment_id, chunk_number, timestamp_us, packet_size, hop_count
  input  logic [111:0] s_tdata,
  // cmd, first_chunk
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rtt_us, hops, throughput, sampled_throughput
  output logic [103:0] m_tdata,
  // status[1:0], throughput_valid, sampled_valid
  output logic [3:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  ppte_pkg::dp_cmd_t cmd;
  ppte_pkg::dp_sts_t sts;
  logic [7:0]        sample_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= ppte_pkg::SAMPLE_COUNT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      sample_count <= pwdata[7:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {24'd0, sample_count};

  ppte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppte_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .sample_count (sample_count),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

endmodule

>>> tb/tb_packet_pair_throughput_estimator.sv
`timescale 1ns / 1ps

module tb_packet_pair_throughput_estimator;

  localparam logic CMD_DATA = 1'b1;

  typedef struct {
    logic        cmd;
    logic [15:0] seg;
    logic [23:0] chunk;
    logic [47:0] ts;
    logic [15:0] size;
    logic [7:0]  hops;
    logic        first;
  } event_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] rtt;
    logic [7:0]  hops;
    logic [31:0] tput;
    logic        tput_valid;
    logic [31:0] mean;
    logic        mean_valid;
  } estimate_t;

  class estimate_board;
    logic [47:0] req_first [64];
    logic [47:0] req_second[64];
    logic [47:0] data_first[64];
    logic [47:0] data_second[64];
    logic [39:0] tag[64];
    bit          present[64];
    logic [5:0]  last_req_slot, last_data_slot;
    bit          last_req_set, last_data_set;
    logic [7:0]  taken;
    logic [47:0] inv_sum;
    logic [7:0]  sample_count;
    estimate_t   pending_q[$];
    int          errors;

    function new();
      for (int i = 0; i < 64; i++) begin
        present[i] = 0;
        req_first[i] = '0; req_second[i] = '0; data_first[i] = '0; data_second[i] = '0;
        tag[i] = '0;
      end
      last_req_slot = 0; last_data_slot = 0;
      last_req_set = 0; last_data_set = 0;
      taken = 0; inv_sum = 0; sample_count = ppte_pkg::SAMPLE_COUNT_RESET;
      errors = 0;
    endfunction

    function bit hit(logic [15:0] seg, logic [23:0] chunk);
      return present[chunk[5:0]] && tag[chunk[5:0]] == {seg, chunk};
    endfunction

    function void note(event_t e);
      logic [5:0]   slot, prev;
      logic [23:0]  pchunk;
      bit           prev_found, first_overall, valid;
      estimate_t    r;
      longint       gap, rtt_first;
      logic [63:0]  mag, q, diff;
      logic [127:0] inv, num, mq;
      logic [48:0]  sum;
      logic [7:0]   need;
      pchunk = e.chunk - 24'd1;
      prev = pchunk[5:0];
      slot = e.chunk[5:0];
      prev_found = e.chunk != 0 && hit(e.seg, pchunk);
      if (e.cmd == ppte_pkg::CMD_REQUEST) begin
        first_overall = 0;
        if (prev_found) req_second[prev] = e.ts;
        else if (last_req_set) req_second[last_req_slot] = e.ts;
        else first_overall = 1;
        if (!hit(e.seg, e.chunk)) begin
          tag[slot] = {e.seg, e.chunk};
          present[slot] = 1;
          req_first[slot] = e.ts;
          req_second[slot] = first_overall ? e.ts : 48'd0;
          data_first[slot] = first_overall ? e.ts : 48'd0;
          data_second[slot] = first_overall ? e.ts : 48'd0;
        end
        last_req_slot = slot;
        last_req_set = 1;
        return;
      end
      r = '{ppte_pkg::STATUS_MEASURED, 32'd0, 8'd0, 32'd0, 1'b0, 32'd0, 1'b0};
      if (!hit(e.seg, e.chunk)) begin
        r.status = ppte_pkg::STATUS_UNKNOWN;
        pending_q.push_back(r);
        return;
      end
      diff = 64'(e.ts) - 64'(req_first[slot]);
      r.rtt = e.ts < req_first[slot] ? 32'd0 : (diff > 64'hFFFFFFFF ? '1 : diff[31:0]);
      r.hops = e.hops;
      if (!prev_found) begin
        if (!last_data_set) begin
          data_first[slot] = e.ts;
          last_data_slot = slot;
          last_data_set = 1;
          r.status = ppte_pkg::STATUS_FIRST;
          pending_q.push_back(r);
          return;
        end
        prev = last_data_slot;
      end
      data_second[prev] = e.ts;
      data_first[slot] = e.ts;
      gap = longint'(64'(data_second[prev])) - longint'(64'(data_first[prev]));
      rtt_first = longint'(64'(data_first[prev])) - longint'(64'(req_first[prev]));
      mag = gap < 0 ? 64'(-gap) : 64'(gap);
      if (mag == 0) mag = 1;
      q = (64'(e.size) * 64'd524288) / mag;
      if (gap >= 0) r.tput = q > 64'h7FFFFFFF ? 32'h7FFFFFFF : q[31:0];
      else r.tput = q > 64'h80000000 ? 32'h80000000 : 32'(-q);
      valid = gap > 0 && rtt_first > 0 && 64'(e.size) * 64'd80 > 64'(gap) && !e.first;
      r.tput_valid = valid;
      if (valid) begin
        need = sample_count == 0 ? 8'd1 : sample_count;
        inv = (128'(gap) << 33) / 128'(e.size);
        sum = 49'(inv_sum) + 49'(inv);
        inv_sum = sum[48] ? '1 : sum[47:0];
        taken = taken + 8'd1;
        if (taken >= need) begin
          num = (128'(taken) * 128'(ppte_pkg::US_PER_S)) << 36;
          if (inv_sum == 0) r.mean = '1;
          else begin
            mq = num / 128'(inv_sum);
            r.mean = mq > 128'hFFFFFFFF ? 32'hFFFFFFFF : mq[31:0];
          end
          r.mean_valid = 1;
          taken = 0;
          inv_sum = 0;
        end
      end
      last_data_slot = slot;
      last_data_set = 1;
      pending_q.push_back(r);
    endfunction

    function void check(estimate_t a);
      estimate_t x;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d rtt %0d", a.status, a.rtt);
        return;
      end
      x = pending_q.pop_front();
      if (x.status !== a.status || x.rtt !== a.rtt || x.hops !== a.hops ||
          x.tput !== a.tput || x.tput_valid !== a.tput_valid ||
          x.mean !== a.mean || x.mean_valid !== a.mean_valid) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp st %0d rtt %h hop %h tp %h tv %b mn %h mv %b",
                   x.status, x.rtt, x.hops, x.tput, x.tput_valid, x.mean, x.mean_valid);
          $display("         act st %0d rtt %h hop %h tp %h tv %b mn %h mv %b",
                   a.status, a.rtt, a.hops, a.tput, a.tput_valid, a.mean, a.mean_valid);
        end
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [103:0] m_tdata;
  logic [3:0]   m_tuser;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  estimate_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  packet_pair_throughput_estimator dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    event_t    e;
    estimate_t a;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        e.cmd = s_tuser[0]; e.first = s_tuser[1];
        {e.hops, e.size, e.ts, e.chunk, e.seg} = s_tdata;
        board.note(e);
      end
      if (m_tvalid && m_tready) begin
        {a.mean, a.tput, a.hops, a.rtt} = m_tdata;
        a.status = m_tuser[1:0]; a.tput_valid = m_tuser[2]; a.mean_valid = m_tuser[3];
        board.check(a);
      end
    end
  end

  function automatic event_t mk(logic cmd, logic [15:0] seg, logic [23:0] chunk,
                                logic [47:0] ts, logic [15:0] size, logic [7:0] hops,
                                logic first);
    event_t e;
    e.cmd = cmd; e.seg = seg; e.chunk = chunk; e.ts = ts;
    e.size = size; e.hops = hops; e.first = first;
    return e;
  endfunction

  task automatic send(event_t e);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {e.hops, e.size, e.ts, e.chunk, e.seg};
    s_tuser <= {e.first, e.cmd};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_sample_count(logic [7:0] v);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 3'd0; pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.sample_count = v;
  endtask

  task automatic random_event();
    event_t e;
    e = mk(1'($urandom_range(1)), 16'($urandom_range(3)), 24'($urandom_range(70)),
           48'({$urandom(), $urandom()}), 16'($urandom()), 8'($urandom()),
           1'($urandom_range(1)));
    if ($urandom_range(3) == 0) begin
      e.seg = 16'($urandom());
      e.chunk = 24'($urandom());
    end
    send(e);
  endtask

  task automatic chunk_run(ref int count);
    logic [15:0] seg;
    logic [23:0] chunk;
    logic [47:0] t;
    int          len;
    seg = 16'($urandom_range(3));
    chunk = $urandom_range(4) == 0 ? 24'd0 : 24'($urandom_range(200));
    if ($urandom_range(9) == 0) chunk = 24'hFFFFFF - 24'($urandom_range(5));
    t = $urandom_range(9) == 0 ? 48'({$urandom(), $urandom()}) : 48'($urandom());
    len = $urandom_range(2, 12);
    for (int k = 0; k < len; k++) begin
      send(mk(ppte_pkg::CMD_REQUEST, seg, chunk, t, 16'($urandom()), 8'($urandom()), 1'b0));
      t += 48'($urandom_range(1, 400));
      send(mk(CMD_DATA, seg, chunk, t, 16'($urandom_range(40, 65535)), 8'($urandom()),
              $urandom_range(9) == 0));
      t += 48'($urandom_range(0, 300));
      chunk++;
      count += 2;
    end
  endtask

  initial begin
    logic [7:0] counts[5];
    int         sizes[5];
    int         count;
    counts = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(2, 20))};
    sizes  = '{200, 480, 150, 200, 200};
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(mk(CMD_DATA, 16'd0, 24'd5, 48'd100, 16'd1000, 8'd1, 0));
    send(mk(ppte_pkg::CMD_REQUEST, 16'hFFFF, 24'hFFFFFF, 48'd0, 16'hFFFF, 8'hFF, 1));
    send(mk(ppte_pkg::CMD_REQUEST, 16'd0, 24'd0, 48'd1000, 16'd0, 8'd0, 0));
    send(mk(CMD_DATA, 16'd0, 24'd0, 48'd1200, 16'd1500, 8'hFF, 1));
    send(mk(ppte_pkg::CMD_REQUEST, 16'd0, 24'd1, 48'd1300, 16'd0, 8'd0, 0));
    send(mk(ppte_pkg::CMD_REQUEST, 16'd0, 24'd1, 48'd1350, 16'd0, 8'd0, 0));
    send(mk(CMD_DATA, 16'd0, 24'd1, 48'd1400, 16'hFFFF, 8'd3, 0));
    send(mk(ppte_pkg::CMD_REQUEST, 16'd0, 24'd2, 48'd1500, 16'd0, 8'd0, 0));
    send(mk(CMD_DATA, 16'd0, 24'd2, 48'd1450, 16'd0, 8'd7, 0));
    send(mk(CMD_DATA, 16'd0, 24'd2, 48'd1300, 16'd500, 8'd7, 0));
    send(mk(ppte_pkg::CMD_REQUEST, 16'd0, 24'd64, 48'd1600, 16'd0, 8'd0, 0));
    send(mk(CMD_DATA, 16'd0, 24'd0, 48'd1700, 16'd100, 8'd0, 0));
    send(mk(CMD_DATA, 16'd0, 24'd64, 48'hFFFFFFFFFFFF, 16'd1, 8'd9, 0));
    send(mk(CMD_DATA, 16'hFFFF, 24'hFFFFFF, 48'hFFFFFFFFFFFF, 16'hFFFF, 8'hFF, 1));
    send(mk(ppte_pkg::CMD_REQUEST, 16'd1, 24'd10, 48'd5000, 16'd0, 8'd0, 0));
    send(mk(ppte_pkg::CMD_REQUEST, 16'd1, 24'd11, 48'd5010, 16'd0, 8'd0, 0));
    send(mk(CMD_DATA, 16'd1, 24'd10, 48'd5050, 16'd1200, 8'd2, 0));
    send(mk(CMD_DATA, 16'd1, 24'd11, 48'd5060, 16'd1200, 8'd2, 0));
    send(mk(CMD_DATA, 16'd1, 24'd11, 48'd5060, 16'd1200, 8'd2, 0));
    drain();

    for (int p = 0; p < 5; p++) begin
      send_idle_pct = p < 2 ? 19 : (p < 4 ? 54 : 0);
      recv_idle_pct = p < 2 ? 54 : (p < 4 ? 19 : 0);
      write_sample_count(counts[p]);
      @(posedge clk);
      count = 0;
      while (count < sizes[p]) begin
        if ($urandom_range(99) < 15) begin
          random_event();
          count++;
        end else chunk_run(count);
        if (p == 1 && count >= 250 && count < 264) begin
          s_tvalid <= 0;
          while (board.pending_q.size() != 0) @(posedge clk);
          count = 264;
        end
      end
      drain();
    end
    write_sample_count(ppte_pkg::SAMPLE_COUNT_RESET);
    @(posedge clk);
    count = 0;
    while (count < 60) chunk_run(count);
    drain();

    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
